// ===== rtl/core/dcbng_pkg.sv =====
// shared widths, register indexes and state codes of the dc blocker and noise gate
package dcbng_pkg;

	// signal and gain formats
	localparam int SIG_FRAC  = 16;
	localparam int GAIN_FRAC = 24;
	localparam int YW        = SIG_FRAC + 18;  // filter and envelope word
	localparam int GW        = GAIN_FRAC + 1;  // gain and coefficient word
	localparam int PW        = YW + GW + 1;    // serial product accumulator
	localparam int MUL_STEPS = GW;             // one multiplier bit per cycle
	localparam int DIV_STEPS = 16;             // one ratio bit per cycle
	localparam int CW        = 5;

	localparam logic [GW-1:0] UNITY = GW'(1) << GAIN_FRAC;

	// configuration register indexes
	localparam logic [2:0] REG_DC_POLE    = 3'd0;
	localparam logic [2:0] REG_SHUT_LEVEL = 3'd1;
	localparam logic [2:0] REG_OPEN_LEVEL = 3'd2;
	localparam logic [2:0] REG_FLOOR_GAIN = 3'd3;
	localparam logic [2:0] REG_RELEASE    = 3'd4;
	localparam logic [2:0] REG_GAIN_SLEW  = 3'd5;

	// input command codes
	localparam logic CMD_SAMPLE  = 1'b0;
	localparam logic CMD_RESTART = 1'b1;

	// sequencer states
	typedef enum logic [9:0] {
		S_IDLE  = 10'b00_0000_0001,
		S_MPOLE = 10'b00_0000_0010,
		S_MENV  = 10'b00_0000_0100,
		S_TSEL  = 10'b00_0000_1000,
		S_DIV   = 10'b00_0001_0000,
		S_MTGT  = 10'b00_0010_0000,
		S_GSEL  = 10'b00_0100_0000,
		S_MSLEW = 10'b00_1000_0000,
		S_MOUT  = 10'b01_0000_0000,
		S_EMIT  = 10'b10_0000_0000
	} state_t;

endpackage

// ===== rtl/core/dc_blocker_soft_noise_gate_top.sv =====
// dc blocker and soft noise gate with a bit-serial shared multiplier and divider
//
// Usage: one signed 16-bit sample per input word on s_axis (tdata = sample_in,
// tuser = command). Command sample gives one word on m_axis (tdata = sample_out,
// tuser = saturated); command restart loads the start values and gives no word.
// A sample is taken only while the sequencer is idle. Each multiply runs one
// multiplier bit per cycle on the shared shift-add unit, and the gate ratio
// divide runs one quotient bit per cycle. The next sample is taken the cycle
// after the result is registered, so a new sample is not taken before the
// last one is finished. A finished word waits in the output register while
// the next sample is taken; if the receiver still stalls when the next result
// is ready, the sequencer holds in its emit step until m_axis_tready.
// Configuration writes (wr_en, wr_index, wr_data) are taken in any cycle and
// must only be made while idle. Reset (arst_n low) loads the register defaults,
// clears the filter, sets the envelope to the open level and the gain to unity.
module dc_blocker_soft_noise_gate_top
	import dcbng_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic signed [15:0]  s_axis_tdata,  // [15:0] sample_in
	input  logic                s_axis_tuser,  // [0] command
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic signed [15:0]  m_axis_tdata,  // [15:0] sample_out
	output logic                m_axis_tuser,  // [0] saturated
	input  logic                wr_en,
	input  logic [2:0]          wr_index,
	input  logic [GW-1:0]       wr_data
);

	state_t state_q;

	// configuration
	logic [14:0]   pole_q;
	logic [16:0]   shut_q, open_q;
	logic [15:0]   floor_q;
	logic [GW-1:0] rel_q, slew_q;

	// filter state
	logic signed [15:0]   x_q, px_q;
	logic signed [YW-1:0] y_q;
	logic [YW-1:0]        env_q;
	logic [GW-1:0]        gain_q, tgt_q;
	logic                 up_q;

	// finished result waiting for the output register
	logic signed [15:0]   res_data_q;
	logic                 res_sat_q;

	// serial units
	logic [YW-1:0] mcand_q;
	logic [GW-1:0] mplier_q;
	logic [PW-1:0] acc_q;
	logic [CW-1:0] cnt_q;
	logic [YW-1:0] rem_q, den_q;
	logic [15:0]   ratio_q;

	logic [PW-1:0] prod_nxt;
	logic [PW-1:0] rnd_pole, rnd_env, rnd_tgt, rnd_slew, rnd_out;
	logic [YW-1:0] pole_mag, env_dec;
	logic signed [YW+1:0] pole_s, y_sum;
	logic signed [YW-1:0] y_new;
	logic [YW-1:0] a_new;
	logic [GW-1:0] tgt_add, slew_d, gain_new, rel_c, slew_c, floor_g;
	logic [YW-1:0] shut_s, open_s;
	logic [YW:0]   rem2;
	logic          div_ge;
	logic [18:0]   out_mag;
	logic [15:0]   fl_c;
	logic          acc_in, mul_last;
	logic          out_neg;

	assign acc_in = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE);
	assign mul_last = (cnt_q == CW'(MUL_STEPS - 1));

	// one shift-add step of the shared multiplier
	assign prod_nxt = {acc_q[PW-2:0], 1'b0} + (mplier_q[GW-1] ? PW'(mcand_q) : '0);

	// clamped configuration and scaled levels
	assign rel_c   = (rel_q > UNITY) ? UNITY : rel_q;
	assign slew_c  = (slew_q > UNITY) ? UNITY : slew_q;
	assign fl_c    = (floor_q > 16'd32768) ? 16'd32768 : floor_q;
	assign floor_g = GW'({fl_c, 9'b0});
	assign shut_s  = YW'({shut_q, 16'b0});
	assign open_s  = YW'({open_q, 16'b0});

	// pole product back to Q.16, then filter sum with saturation
	assign rnd_pole = prod_nxt + (PW'(1) << 14);
	assign pole_mag = rnd_pole[YW+14:15];
	assign pole_s   = y_q[YW-1] ? -$signed({2'b00, pole_mag}) : $signed({2'b00, pole_mag});
	assign y_sum    = $signed((YW+2)'($signed({x_q[15], x_q} - {px_q[15], px_q})) <<< 16)
	                  + pole_s;
	always_comb begin
		if (y_sum > $signed((YW+2)'((64'd1 << (YW-1)) - 64'd1)))
			y_new = {1'b0, {(YW-1){1'b1}}};
		else if (y_sum < -$signed((YW+2)'(64'd1 << (YW-1))))
			y_new = {1'b1, {(YW-1){1'b0}}};
		else
			y_new = y_sum[YW-1:0];
	end
	assign a_new = y_new[YW-1] ? YW'(-y_new) : YW'(y_new);

	// rounded steps of the other products
	assign rnd_env  = prod_nxt + (PW'(1) << (GAIN_FRAC - 1));
	assign env_dec  = rnd_env[YW+GAIN_FRAC-1:GAIN_FRAC];
	assign rnd_tgt  = prod_nxt + (PW'(1) << 15);
	assign tgt_add  = rnd_tgt[GW+15:16];
	assign rnd_slew = prod_nxt + (PW'(1) << (GAIN_FRAC - 1));
	assign slew_d   = rnd_slew[GW+GAIN_FRAC-1:GAIN_FRAC];
	assign gain_new = up_q ? gain_q + slew_d : gain_q - slew_d;
	assign rnd_out  = prod_nxt + (PW'(1) << (SIG_FRAC + GAIN_FRAC - 1));
	assign out_mag  = rnd_out[SIG_FRAC+GAIN_FRAC+18:SIG_FRAC+GAIN_FRAC];
	assign out_neg  = y_q[YW-1];

	// restoring divide step
	assign rem2   = {rem_q, 1'b0};
	assign div_ge = rem2 >= {1'b0, den_q};

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
			m_axis_tdata  <= '0;
			m_axis_tuser  <= 1'b0;
		end else if (state_q == S_EMIT && (!m_axis_tvalid || m_axis_tready)) begin
			m_axis_tvalid <= 1'b1;
			m_axis_tdata  <= res_data_q;
			m_axis_tuser  <= res_sat_q;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pole_q  <= 15'd32604;
			shut_q  <= 17'd200;
			open_q  <= 17'd800;
			floor_q <= 16'd9830;
			rel_q   <= GW'(13422);
			slew_q  <= GW'(100663);
		end else if (wr_en) begin
			case (wr_index)
				REG_DC_POLE:    pole_q  <= wr_data[14:0];
				REG_SHUT_LEVEL: shut_q  <= wr_data[16:0];
				REG_OPEN_LEVEL: open_q  <= wr_data[16:0];
				REG_FLOOR_GAIN: floor_q <= wr_data[15:0];
				REG_RELEASE:    rel_q   <= wr_data;
				REG_GAIN_SLEW:  slew_q  <= wr_data;
				default: ;
			endcase
		end
	end

	// sequencer and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			px_q    <= '0;
			y_q     <= '0;
			env_q   <= YW'(800) << SIG_FRAC;
			gain_q  <= UNITY;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (acc_in) begin
						if (s_axis_tuser == CMD_RESTART) begin
							px_q   <= '0;
							y_q    <= '0;
							env_q  <= open_s;
							gain_q <= UNITY;
						end else begin
							x_q      <= s_axis_tdata;
							mcand_q  <= y_q[YW-1] ? YW'(-y_q) : YW'(y_q);
							mplier_q <= GW'(pole_q);
							acc_q    <= '0;
							cnt_q    <= '0;
							state_q  <= S_MPOLE;
						end
					end
				end
				S_MPOLE: begin
					if (mul_last) begin
						px_q  <= x_q;
						y_q   <= y_new;
						cnt_q <= '0;
						if (a_new > env_q) begin
							env_q   <= a_new;
							state_q <= S_TSEL;
						end else begin
							mcand_q  <= env_q - a_new;
							mplier_q <= rel_c;
							acc_q    <= '0;
							state_q  <= S_MENV;
						end
					end else begin
						acc_q    <= prod_nxt;
						mplier_q <= mplier_q << 1;
						cnt_q    <= cnt_q + CW'(1);
					end
				end
				S_MENV: begin
					if (mul_last) begin
						env_q   <= env_q - env_dec;
						cnt_q   <= '0;
						state_q <= S_TSEL;
					end else begin
						acc_q    <= prod_nxt;
						mplier_q <= mplier_q << 1;
						cnt_q    <= cnt_q + CW'(1);
					end
				end
				S_TSEL: begin
					// unity at or above open, floor at or below shut, ramp between
					if (env_q >= open_s) begin
						tgt_q   <= UNITY;
						state_q <= S_GSEL;
					end else if (env_q <= shut_s) begin
						tgt_q   <= floor_g;
						state_q <= S_GSEL;
					end else begin
						rem_q   <= env_q - shut_s;
						den_q   <= open_s - shut_s;
						ratio_q <= '0;
						cnt_q   <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					rem_q   <= div_ge ? YW'(rem2 - {1'b0, den_q}) : rem2[YW-1:0];
					ratio_q <= {ratio_q[14:0], div_ge};
					if (cnt_q == CW'(DIV_STEPS - 1)) begin
						mcand_q  <= YW'(UNITY - floor_g);
						mplier_q <= GW'({ratio_q[14:0], div_ge});
						acc_q    <= '0;
						cnt_q    <= '0;
						state_q  <= S_MTGT;
					end else begin
						cnt_q    <= cnt_q + CW'(1);
					end
				end
				S_MTGT: begin
					if (mul_last) begin
						tgt_q   <= floor_g + tgt_add;
						cnt_q   <= '0;
						state_q <= S_GSEL;
					end else begin
						acc_q    <= prod_nxt;
						mplier_q <= mplier_q << 1;
						cnt_q    <= cnt_q + CW'(1);
					end
				end
				S_GSEL: begin
					up_q     <= tgt_q >= gain_q;
					mcand_q  <= (tgt_q >= gain_q) ? YW'(tgt_q - gain_q) : YW'(gain_q - tgt_q);
					mplier_q <= slew_c;
					acc_q    <= '0;
					cnt_q    <= '0;
					state_q  <= S_MSLEW;
				end
				S_MSLEW: begin
					if (mul_last) begin
						gain_q   <= gain_new;
						mcand_q  <= y_q[YW-1] ? YW'(-y_q) : YW'(y_q);
						mplier_q <= gain_new;
						acc_q    <= '0;
						cnt_q    <= '0;
						state_q  <= S_MOUT;
					end else begin
						acc_q    <= prod_nxt;
						mplier_q <= mplier_q << 1;
						cnt_q    <= cnt_q + CW'(1);
					end
				end
				S_MOUT: begin
					if (mul_last) begin
						cnt_q   <= '0;
						state_q <= S_EMIT;
						// round magnitude, then clamp to int16
						if (out_neg) begin
							res_sat_q  <= out_mag > 19'd32768;
							res_data_q <= (out_mag > 19'd32768) ? 16'sh8000
							              : 16'(-out_mag);
						end else begin
							res_sat_q  <= out_mag > 19'd32767;
							res_data_q <= (out_mag > 19'd32767) ? 16'sh7fff
							              : out_mag[15:0];
						end
					end else begin
						acc_q    <= prod_nxt;
						mplier_q <= mplier_q << 1;
						cnt_q    <= cnt_q + CW'(1);
					end
				end
				S_EMIT: begin
					if (!m_axis_tvalid || m_axis_tready)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	// a restart word gives no work and no result
	a_restart_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_in && s_axis_tuser == CMD_RESTART) |=> (state_q == S_IDLE && !$rose(m_axis_tvalid)))
		else $error("restart started the sequencer");

	// a sample word starts the pole multiply
	a_sample_start: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_in && s_axis_tuser == CMD_SAMPLE) |=> state_q == S_MPOLE)
		else $error("sample did not start the filter");

	// the divide remainder stays below the divisor
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (rem_q < den_q))
		else $error("divide remainder out of range");

	// a result word only appears out of the emit step
	a_emit_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q) == S_EMIT)
		else $error("output valid without emit");
`endif

endmodule
